[rtl/lsfs_pkg.sv]
// shared types, constants and helpers for the led strip frame streamer
package lsfs_pkg;

    // frame store geometry
    localparam int MAX_LEDS = 256;
    localparam int ADDR_W   = $clog2(MAX_LEDS);
    localparam int COUNT_W  = 9;
    localparam int POS_W    = 10;
    localparam int COLOUR_W = 24;

    // reset value of the led count register
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_LEDS);

    // colour reserved for the latch pattern and its clamped replacement
    localparam logic [COLOUR_W-1:0] COLOUR_ALL_ONES = 24'hFFFFFF;
    localparam logic [COLOUR_W-1:0] COLOUR_CLAMPED  = 24'hFFFFFE;

    // command codes
    localparam logic [2:0] CMD_SET   = 3'd0;
    localparam logic [2:0] CMD_GET   = 3'd1;
    localparam logic [2:0] CMD_CLEAR = 3'd2;
    localparam logic [2:0] CMD_START = 3'd3;
    localparam logic [2:0] CMD_TICK  = 3'd4;

    // request payload
    typedef struct packed {
        logic [2:0]          command;
        logic [ADDR_W-1:0]   led_index;
        logic [COLOUR_W-1:0] colour;
    } req_t;

    // result payload
    typedef struct packed {
        logic [7:0]          tx_byte;
        logic [COLOUR_W-1:0] read_colour;
        logic                transfer_done;
    } res_t;

    // controller commands to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_t;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // latch trailer bytes 7F FF FF 80
    function automatic logic [7:0] trailer_byte(input logic [1:0] sel);
        logic [7:0] b;
        case (sel)
            2'd0:    b = 8'h7F;
            2'd1:    b = 8'hFF;
            2'd2:    b = 8'hFF;
            default: b = 8'h80;
        endcase
        return b;
    endfunction

endpackage

[rtl/led_strip_frame_streamer_unit.sv]
// top level of the led strip frame streamer
// Each request is taken when start is high and busy is low, busy is high for the
// following cycle while the frame store read completes, and the result appears
// with result_valid for exactly one cycle after that; a new request is accepted
// only while busy is low, so requests never overlap. The receiver cannot stall;
// every request yields one result. Clear empties the whole store at once through
// per-entry valid flags and needs no sweep. The led count register may be written
// at any time through cfg_we and cfg_data and is compared live during a transfer.
module led_strip_frame_streamer_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  lsfs_pkg::req_t               req,
    input  logic                         cfg_we,
    input  logic [lsfs_pkg::COUNT_W-1:0] cfg_data,
    output logic                         result_valid,
    output lsfs_pkg::res_t               result
);

    lsfs_pkg::ctrl_t ctl;

    // sequencer
    lsfs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctl   (ctl)
    );

    // store and transfer datapath
    lsfs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .req          (req),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

[rtl/lsfs_ctrl.sv]
// request sequencer: capture cycle then execute cycle
module lsfs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output lsfs_pkg::ctrl_t ctl
);

    lsfs_pkg::state_t state_reg;
    lsfs_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsfs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lsfs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = lsfs_pkg::ST_EXEC;
                end
            end
            lsfs_pkg::ST_EXEC:
            begin
                state_next = lsfs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lsfs_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctl.capture = 1'b0;
        ctl.execute = 1'b0;
        busy        = 1'b0;
        case (state_reg)
            lsfs_pkg::ST_IDLE:
            begin
                ctl.capture = start;
            end
            lsfs_pkg::ST_EXEC:
            begin
                ctl.execute = 1'b1;
                busy        = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // every execute cycle follows a capture
    a_exec_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.execute |-> $past(ctl.capture))
        else $error("execute without a captured request");

endmodule

[rtl/lsfs_datapath.sv]
// frame store, transfer position counters, led count register and result register
module lsfs_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lsfs_pkg::ctrl_t              ctl,
    input  lsfs_pkg::req_t               req,
    input  logic                         cfg_we,
    input  logic [lsfs_pkg::COUNT_W-1:0] cfg_data,
    output logic                         result_valid,
    output lsfs_pkg::res_t               result
);

    logic [lsfs_pkg::COLOUR_W-1:0] mem [lsfs_pkg::MAX_LEDS];
    logic [lsfs_pkg::MAX_LEDS-1:0] valid_reg;
    logic [lsfs_pkg::MAX_LEDS-1:0] valid_next;

    logic [lsfs_pkg::COUNT_W-1:0]  led_count_reg;
    logic                          sending_reg;
    logic                          sending_next;
    logic [lsfs_pkg::POS_W-1:0]    pos_reg;
    logic [lsfs_pkg::POS_W-1:0]    pos_next;
    logic [lsfs_pkg::COUNT_W-1:0]  led_ptr_reg;
    logic [lsfs_pkg::COUNT_W-1:0]  led_ptr_next;
    logic [1:0]                    sub_reg;
    logic [1:0]                    sub_next;

    lsfs_pkg::req_t                cmd_reg;
    logic [lsfs_pkg::COLOUR_W-1:0] rdata_reg;
    logic                          rvalid_reg;
    logic [lsfs_pkg::ADDR_W-1:0]   rd_addr;

    logic                          result_valid_reg;
    lsfs_pkg::res_t                result_reg;
    lsfs_pkg::res_t                result_next;

    logic [lsfs_pkg::COUNT_W-1:0]  eff_count;
    logic                          in_range;
    logic [lsfs_pkg::POS_W-1:0]    data_len;
    logic [lsfs_pkg::POS_W-1:0]    frame_len;
    logic [lsfs_pkg::POS_W-1:0]    pos_inc;
    logic [lsfs_pkg::POS_W-1:0]    pos_diff;
    logic [lsfs_pkg::COLOUR_W-1:0] stored_colour;
    logic [7:0]                    data_byte;
    logic [7:0]                    tick_byte;
    logic [lsfs_pkg::COLOUR_W-1:0] wr_colour;
    logic                          wr_en;
    logic [lsfs_pkg::POS_W:0]      pos_check;

    // effective count and frame lengths, compared live against the position
    always_comb
    begin
        eff_count = (led_count_reg > lsfs_pkg::COUNT_W'(lsfs_pkg::MAX_LEDS))
                  ? lsfs_pkg::COUNT_W'(lsfs_pkg::MAX_LEDS) : led_count_reg;
        data_len  = {eff_count, 1'b0} + {1'b0, eff_count};
        frame_len = data_len + lsfs_pkg::POS_W'(4);
        pos_inc   = pos_reg + lsfs_pkg::POS_W'(1);
        pos_diff  = pos_reg - data_len;
        in_range  = {1'b0, cmd_reg.led_index} < eff_count;
    end

    // read address: the led under the transfer pointer for a tick, else the request index
    assign rd_addr = (req.command == lsfs_pkg::CMD_TICK)
                   ? led_ptr_reg[lsfs_pkg::ADDR_W-1:0] : req.led_index;

    // colour of the addressed entry, zero when never written since reset or clear
    assign stored_colour = rvalid_reg ? rdata_reg : '0;

    // colour byte of the current led, high byte first
    always_comb
    begin
        case (sub_reg)
            2'd0:    data_byte = stored_colour[23:16];
            2'd1:    data_byte = stored_colour[15:8];
            default: data_byte = stored_colour[7:0];
        endcase
    end

    // byte for a tick while sending
    always_comb
    begin
        if (pos_reg < data_len)
        begin
            tick_byte = data_byte;
        end
        else if (pos_reg < frame_len)
        begin
            tick_byte = lsfs_pkg::trailer_byte(pos_diff[1:0]);
        end
        else
        begin
            tick_byte = 8'h00;
        end
    end

    // set clamps the reserved all-ones pattern
    assign wr_colour = (cmd_reg.colour == lsfs_pkg::COLOUR_ALL_ONES)
                     ? lsfs_pkg::COLOUR_CLAMPED : cmd_reg.colour;
    assign wr_en     = ctl.execute && (cmd_reg.command == lsfs_pkg::CMD_SET) && in_range;

    // command execution
    always_comb
    begin
        sending_next            = sending_reg;
        pos_next                = pos_reg;
        led_ptr_next            = led_ptr_reg;
        sub_next                = sub_reg;
        valid_next              = valid_reg;
        result_next.tx_byte     = 8'h00;
        result_next.read_colour = '0;
        if (ctl.execute)
        begin
            case (cmd_reg.command)
                lsfs_pkg::CMD_SET:
                begin
                    if (in_range)
                    begin
                        valid_next[cmd_reg.led_index] = 1'b1;
                    end
                end
                lsfs_pkg::CMD_GET:
                begin
                    if (in_range)
                    begin
                        result_next.read_colour = stored_colour;
                    end
                end
                lsfs_pkg::CMD_CLEAR, lsfs_pkg::CMD_START:
                begin
                    if (cmd_reg.command == lsfs_pkg::CMD_CLEAR)
                    begin
                        valid_next = '0;
                    end
                    if (!sending_reg)
                    begin
                        sending_next = 1'b1;
                        pos_next     = '0;
                        led_ptr_next = '0;
                        sub_next     = 2'd0;
                    end
                end
                lsfs_pkg::CMD_TICK:
                begin
                    if (sending_reg)
                    begin
                        result_next.tx_byte = tick_byte;
                        if (pos_inc >= frame_len)
                        begin
                            sending_next = 1'b0;
                            pos_next     = '0;
                            led_ptr_next = '0;
                            sub_next     = 2'd0;
                        end
                        else
                        begin
                            pos_next = pos_inc;
                            if (sub_reg == 2'd2)
                            begin
                                sub_next     = 2'd0;
                                led_ptr_next = led_ptr_reg + lsfs_pkg::COUNT_W'(1);
                            end
                            else
                            begin
                                sub_next = sub_reg + 2'd1;
                            end
                        end
                    end
                end
                default:
                begin
                    sending_next = sending_reg;
                end
            endcase
        end
        result_next.transfer_done = !sending_next;
    end

    // control state and led count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg    <= lsfs_pkg::COUNT_RESET;
            sending_reg      <= 1'b0;
            pos_reg          <= '0;
            led_ptr_reg      <= '0;
            sub_reg          <= 2'd0;
            valid_reg        <= '0;
            rvalid_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                led_count_reg <= cfg_data;
            end
            sending_reg      <= sending_next;
            pos_reg          <= pos_next;
            led_ptr_reg      <= led_ptr_next;
            sub_reg          <= sub_next;
            valid_reg        <= valid_next;
            result_valid_reg <= ctl.execute;
            if (ctl.capture)
            begin
                rvalid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // frame store and captured request
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= req;
            rdata_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[cmd_reg.led_index] <= wr_colour;
        end
        if (ctl.execute)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // position must equal three bytes per led plus the byte within the led
    assign pos_check = {1'b0, led_ptr_reg, 1'b0} + {2'b00, led_ptr_reg}
                     + {{(lsfs_pkg::POS_W-1){1'b0}}, sub_reg};

    a_pos_split: assert property (@(posedge clk) disable iff (!rst_n)
        pos_check == {1'b0, pos_reg})
        else $error("byte position out of step with led pointer");

    a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg != 2'd3)
        else $error("byte-in-led counter out of range");

    a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
        !sending_reg |-> (pos_reg == '0))
        else $error("position not parked while idle");

    a_tx_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && ($past(cmd_reg.command) != lsfs_pkg::CMD_TICK))
        |-> (result_reg.tx_byte == 8'h00))
        else $error("serial byte on a non-tick request");

endmodule
